// ===== design/prr_pkg.sv =====
package prr_pkg;

   localparam int TASK_COUNT_DEF = 8;
   localparam int PRIO_W         = 8;
   localparam int DELAY_W        = 32;

   localparam logic [1:0] ST_READY   = 2'd0;
   localparam logic [1:0] ST_RUNNING = 2'd1;
   localparam logic [1:0] ST_BLOCKED = 2'd2;

   localparam logic [2:0] FN_TICK     = 3'd0;
   localparam logic [2:0] FN_SCHEDULE = 3'd1;
   localparam logic [2:0] FN_BLOCK    = 3'd2;
   localparam logic [2:0] FN_UNBLOCK  = 3'd3;
   localparam logic [2:0] FN_READ     = 3'd4;

   typedef struct packed {
      logic [1:0]         status;
      logic [DELAY_W-1:0] count;
   } entry_type;

endpackage

// ===== design/prr_ram.sv =====
module prr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/priority_round_robin_task_scheduler.sv =====
// Task scheduler over TASK_COUNT slots kept in one table RAM (status and
// countdown per slot, one read and one write port, registered read).
//
// Channels: req_* carries one operation (tick, schedule, block current,
// unblock, read delay); rsp_* returns one result per request: the current
// slot, a switch flag and the read delay. csr_* writes the packed priority
// register; it is always ready and must only be written while idle.
//
// Block and unknown codes go from accept straight to the result stage, unblock
// and read delay first read the slot from the table (an index out of range
// skips the read), a tick is one sweep over the slots and a schedule two
// sweeps (highest priority, then round-robin) plus two writes, all through
// the one table port. One request is worked on at a time; a new one is taken
// while a finished result still waits in the output register.
//
// Reset clears the priorities, makes the last (idle) slot current and runs a
// clearing pass over every slot of the table during which req_ready stays
// low. A stalled receiver holds the result; the next request finishes its
// work and then waits until the output register frees.
module priority_round_robin_task_scheduler
   import prr_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [2:0]   req_func,
   input  logic [7:0]   req_task_index,
   input  logic [31:0]  req_timeout_ticks,
   input  logic         req_wait_forever,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_next_task,
   output logic         rsp_task_switched,
   output logic [31:0]  rsp_remaining_delay,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [63:0]  csr_task_priorities
);

   localparam int AW = $clog2(TASK_COUNT);
   localparam int CW = $clog2(TASK_COUNT + 1);
   localparam logic [CW-1:0] LAST_STEP = CW'(TASK_COUNT);
   localparam logic [CW-1:0] LAST_SLOT_CNT = CW'(TASK_COUNT - 1);
   localparam logic [AW-1:0] IDLE_SLOT = AW'(TASK_COUNT - 1);
   localparam logic [7:0] IDX_LIMIT = 8'(TASK_COUNT);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_TICK  = 4'd2;
   localparam logic [3:0] S_MAX   = 4'd3;
   localparam logic [3:0] S_RR    = 4'd4;
   localparam logic [3:0] S_W1    = 4'd5;
   localparam logic [3:0] S_W2    = 4'd6;
   localparam logic [3:0] S_RD1   = 4'd7;
   localparam logic [3:0] S_RD2   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic [AW-1:0]      prev_cur_ff, prev_cur_in;
   logic [2:0]         func_ff, func_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [PRIO_W-1:0]  best_ff, best_in;
   logic               found_ff, found_in;
   logic [AW-1:0]      tgt_ff, tgt_in;
   logic [DELAY_W-1:0] tgt_cnt_ff, tgt_cnt_in;
   entry_type          cur_ent_ff, cur_ent_in;
   logic [DELAY_W-1:0] idle_cnt_ff, idle_cnt_in;
   logic [AW-1:0]      rr_prev_ff, rr_prev_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic               sw_ff, sw_in;
   logic [63:0]        prio_ff, prio_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_task_ff, rsp_task_in;
   logic               rsp_sw_ff, rsp_sw_in;
   logic [DELAY_W-1:0] rsp_delay_ff, rsp_delay_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   entry_type          ram_wdata;
   logic [AW-1:0]      ram_raddr;
   entry_type          ram_rdata;

   logic [AW-1:0]      sweep_addr;
   logic [CW:0]        rr_sum;
   logic [AW-1:0]      rr_addr;
   logic [AW-1:0]      proc_addr;
   logic [1:0]         eff_status;
   logic [PRIO_W-1:0]  proc_prio;
   logic [1:0]         cur_eff_status;
   logic               req_fire;

   prr_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TASK_COUNT)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign sweep_addr = cnt_ff[AW-1:0];
   always_comb begin
      rr_sum = (CW+1)'(cur_ff) + (CW+1)'(cnt_ff) + (CW+1)'(1);
      if (rr_sum >= (CW+1)'(TASK_COUNT)) begin
         rr_sum = rr_sum - (CW+1)'(TASK_COUNT);
      end
      rr_addr = rr_sum[AW-1:0];
   end

   // slot whose entry is on the read data this cycle
   assign proc_addr = (state_ff == S_RR) ? rr_prev_ff : AW'(cnt_ff - CW'(1));
   assign proc_prio = prio_ff[8*proc_addr +: 8];
   // the running current slot counts as ready while scheduling
   assign eff_status = (proc_addr == cur_ff && ram_rdata.status == ST_RUNNING) ?
                       ST_READY : ram_rdata.status;
   assign cur_eff_status = (cur_ent_ff.status == ST_RUNNING) ? ST_READY : cur_ent_ff.status;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      prev_cur_in  = prev_cur_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      tgt_in       = tgt_ff;
      tgt_cnt_in   = tgt_cnt_ff;
      cur_ent_in   = cur_ent_ff;
      idle_cnt_in  = idle_cnt_ff;
      rr_prev_in   = rr_prev_ff;
      delay_in     = delay_ff;
      sw_in        = sw_ff;
      prio_in      = (csr_valid && csr_ready) ? csr_task_priorities : prio_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_task_in  = rsp_task_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_delay_in = rsp_delay_ff;
      ram_we       = 1'b0;
      ram_waddr    = sweep_addr;
      ram_wdata    = '{status: ST_READY, count: '0};
      ram_raddr    = sweep_addr;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == LAST_SLOT_CNT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               func_in     = req_func;
               idx_in      = req_task_index[AW-1:0];
               cnt_in      = '0;
               best_in     = '0;
               found_in    = 1'b0;
               sw_in       = 1'b0;
               delay_in    = '0;
               prev_cur_in = cur_ff;
               unique case (req_func)
                  FN_TICK:     state_in = S_TICK;
                  FN_SCHEDULE: state_in = S_MAX;
                  FN_BLOCK: begin
                     ram_we    = 1'b1;
                     ram_waddr = cur_ff;
                     ram_wdata = '{status: ST_BLOCKED,
                                   count: req_wait_forever ? '0 : req_timeout_ticks};
                     state_in  = S_FIN;
                  end
                  FN_UNBLOCK, FN_READ: begin
                     state_in = (req_task_index < IDX_LIMIT) ? S_RD1 : S_FIN;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_TICK: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff != '0 && ram_rdata.status == ST_BLOCKED && ram_rdata.count != '0) begin
               ram_we    = 1'b1;
               ram_waddr = proc_addr;
               ram_wdata.count  = ram_rdata.count - DELAY_W'(1);
               ram_wdata.status = (ram_rdata.count == DELAY_W'(1)) ? ST_READY : ST_BLOCKED;
            end
            if (cnt_ff == LAST_STEP) begin
               state_in = S_FIN;
            end
         end
         S_MAX: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff != '0) begin
               if (eff_status == ST_READY && proc_prio > best_ff) begin
                  best_in = proc_prio;
               end
               if (proc_addr == cur_ff) begin
                  cur_ent_in = ram_rdata;
               end
               if (proc_addr == IDLE_SLOT) begin
                  idle_cnt_in = ram_rdata.count;
               end
            end
            if (cnt_ff == LAST_STEP) begin
               state_in = S_RR;
               cnt_in   = '0;
            end
         end
         S_RR: begin
            ram_raddr  = rr_addr;
            rr_prev_in = rr_addr;
            cnt_in     = cnt_ff + CW'(1);
            if (cnt_ff != '0 && !found_ff && eff_status == ST_READY && proc_prio == best_ff) begin
               found_in   = 1'b1;
               tgt_in     = proc_addr;
               tgt_cnt_in = ram_rdata.count;
            end
            if (cnt_ff == LAST_STEP) begin
               state_in = S_W1;
            end
         end
         S_W1: begin
            // demote the running current slot
            if (cur_ent_ff.status == ST_RUNNING) begin
               ram_we    = 1'b1;
               ram_waddr = cur_ff;
               ram_wdata = '{status: ST_READY, count: cur_ent_ff.count};
            end
            state_in = S_W2;
         end
         S_W2: begin
            ram_we = 1'b1;
            priority if (found_ff) begin
               ram_waddr = tgt_ff;
               ram_wdata = '{status: ST_RUNNING, count: tgt_cnt_ff};
            end else if (cur_eff_status != ST_BLOCKED) begin
               ram_waddr = cur_ff;
               ram_wdata = '{status: ST_RUNNING, count: cur_ent_ff.count};
            end else begin
               ram_waddr = IDLE_SLOT;
               ram_wdata = '{status: ST_RUNNING, count: idle_cnt_ff};
            end
            cur_in   = ram_waddr;
            sw_in    = (ram_waddr != prev_cur_ff);
            state_in = S_FIN;
         end
         S_RD1: begin
            ram_raddr = idx_ff;
            state_in  = S_RD2;
         end
         S_RD2: begin
            if (func_ff == FN_READ) begin
               delay_in = ram_rdata.count;
            end else if (ram_rdata.status == ST_BLOCKED) begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff;
               ram_wdata = '{status: ST_READY, count: ram_rdata.count};
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = 3'(cur_ff);
               rsp_sw_in    = sw_ff;
               rsp_delay_in = delay_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         cur_ff       <= IDLE_SLOT;
         prio_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_ff       <= cur_in;
         prio_ff      <= prio_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_cur_ff  <= prev_cur_in;
      func_ff      <= func_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      found_ff     <= found_in;
      tgt_ff       <= tgt_in;
      tgt_cnt_ff   <= tgt_cnt_in;
      cur_ent_ff   <= cur_ent_in;
      idle_cnt_ff  <= idle_cnt_in;
      rr_prev_ff   <= rr_prev_in;
      delay_ff     <= delay_in;
      sw_ff        <= sw_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_sw_ff    <= rsp_sw_in;
      rsp_delay_ff <= rsp_delay_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_task       = rsp_task_ff;
   assign rsp_task_switched   = rsp_sw_ff;
   assign rsp_remaining_delay = rsp_delay_ff;

endmodule

// ===== design/prr_checker.sv =====
module prr_checker
   import prr_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF
) (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic [2:0]   req_func,
   input logic [7:0]   req_task_index,
   input logic [31:0]  req_timeout_ticks,
   input logic         req_wait_forever,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [2:0]   rsp_next_task,
   input logic         rsp_task_switched,
   input logic [31:0]  rsp_remaining_delay,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [63:0]  csr_task_priorities
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_task)
         && $stable(rsp_task_switched) && $stable(rsp_remaining_delay))
      else $error("result dropped or changed while stalled");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_next_task} < 4'(TASK_COUNT))
      else $error("next task outside the slot range");

   a_switch_no_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_task_switched |-> rsp_remaining_delay == '0)
      else $error("switch flag and delay in one result");

   a_clear_pass: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request taken during table clearing");

endmodule

bind priority_round_robin_task_scheduler prr_checker #(.TASK_COUNT(TASK_COUNT)) u_prr_checker (.*);

// ===== tb/sv/priority_round_robin_task_scheduler_test.sv =====
`timescale 1ns / 100ps

module priority_round_robin_task_scheduler_test;
   import prr_pkg::*;

   localparam int SLOT_COUNT = 8;
   localparam int RANDOM_REQUESTS = 1830;

   typedef struct packed {
      logic [2:0]  next_task;
      logic        task_switched;
      logic [31:0] remaining_delay;
   } sched_result_type;

   typedef struct {
      logic [2:0]  func;
      logic [7:0]  task_index;
      logic [31:0] timeout_ticks;
      logic        wait_forever;
      logic        check_fixed;
      sched_result_type fixed;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_func;
   logic [7:0]  req_task_index;
   logic [31:0] req_timeout_ticks;
   logic        req_wait_forever;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_next_task;
   logic        rsp_task_switched;
   logic [31:0] rsp_remaining_delay;
   logic        csr_valid;
   logic        csr_ready;
   logic [63:0] csr_task_priorities;

   // scheduler shadow state
   logic [63:0] prio_word;
   logic [1:0]  slot_status [SLOT_COUNT];
   logic [31:0] slot_count [SLOT_COUNT];
   logic [2:0]  cur_slot;

   sched_result_type pending_results[$];
   int   failures;
   int   send_idle_pct;
   int   recv_idle_pct;

   priority_round_robin_task_scheduler u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_task_index(req_task_index), .req_timeout_ticks(req_timeout_ticks),
      .req_wait_forever(req_wait_forever),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_next_task(rsp_next_task),
      .rsp_task_switched(rsp_task_switched), .rsp_remaining_delay(rsp_remaining_delay),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_task_priorities(csr_task_priorities)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [7:0] slot_prio(int s);
      return prio_word[s*8 +: 8];
   endfunction

   function automatic sched_result_type apply_request(logic [2:0] func, logic [7:0] idx,
                                                      logic [31:0] tmo, logic wf);
      sched_result_type r;
      logic [7:0] best;
      int prev;
      int s;
      bit found;
      r = '0;
      unique case (func)
         FN_TICK: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               if (slot_status[i] == ST_BLOCKED && slot_count[i] != 0) begin
                  slot_count[i] = slot_count[i] - 1;
                  if (slot_count[i] == 0) slot_status[i] = ST_READY;
               end
         end
         FN_SCHEDULE: begin
            prev = int'(cur_slot);
            if (slot_status[prev] == ST_RUNNING) slot_status[prev] = ST_READY;
            best = 0;
            for (int i = 0; i < SLOT_COUNT; i++)
               if (slot_status[i] == ST_READY && slot_prio(i) > best) best = slot_prio(i);
            found = 0;
            for (int i = 1; i <= SLOT_COUNT; i++) begin
               s = (prev + i) % SLOT_COUNT;
               if (!found && slot_status[s] == ST_READY && slot_prio(s) == best) begin
                  slot_status[s] = ST_RUNNING;
                  cur_slot = 3'(s);
                  found = 1;
               end
            end
            if (!found) begin
               if (slot_status[prev] == ST_BLOCKED) cur_slot = 3'(SLOT_COUNT - 1);
               slot_status[cur_slot] = ST_RUNNING;
            end
            r.task_switched = (int'(cur_slot) != prev);
         end
         FN_BLOCK: begin
            slot_count[cur_slot] = wf ? 32'd0 : tmo;
            slot_status[cur_slot] = ST_BLOCKED;
         end
         FN_UNBLOCK: begin
            if (idx < SLOT_COUNT && slot_status[idx[2:0]] == ST_BLOCKED)
               slot_status[idx[2:0]] = ST_READY;
         end
         FN_READ: begin
            if (idx < SLOT_COUNT) r.remaining_delay = slot_count[idx[2:0]];
         end
         default: ;
      endcase
      r.next_task = cur_slot;
      return r;
   endfunction

   // result checker and receiver stall
   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result next_task=%0d", rsp_next_task);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_next_task !== want.next_task) begin
                  $error("next_task expected %0d actual %0d", want.next_task, rsp_next_task);
                  failures++;
               end
               if (rsp_task_switched !== want.task_switched) begin
                  $error("task_switched expected %0d actual %0d",
                         want.task_switched, rsp_task_switched);
                  failures++;
               end
               if (rsp_remaining_delay !== want.remaining_delay) begin
                  $error("remaining_delay expected %0d actual %0d",
                         want.remaining_delay, rsp_remaining_delay);
                  failures++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(logic [2:0] func, logic [7:0] idx, logic [31:0] tmo,
                               logic wf, logic check_fixed, sched_result_type fixed);
      sched_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_task_index    <= idx;
      req_timeout_ticks <= tmo;
      req_wait_forever  <= wf;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = apply_request(func, idx, tmo, wf);
      if (check_fixed && r != fixed) begin
         $error("directed row expected %h, predictor gives %h", fixed, r);
         failures++;
      end
      pending_results.push_back(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2 * SLOT_COUNT + 10) @(posedge clock);
   endtask

   task automatic write_priorities(logic [63:0] value);
      csr_valid           <= 1'b1;
      csr_task_priorities <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      prio_word = value;
      csr_valid <= 1'b0;
   endtask

   task automatic send_random();
      int pick;
      logic [2:0]  func;
      logic [7:0]  idx;
      logic [31:0] tmo;
      pick = $urandom_range(99);
      if (pick < 30) func = FN_TICK;
      else if (pick < 55) func = FN_SCHEDULE;
      else if (pick < 68) func = FN_BLOCK;
      else if (pick < 83) func = FN_UNBLOCK;
      else if (pick < 97) func = FN_READ;
      else func = 3'($urandom_range(7, 5));
      idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(SLOT_COUNT - 1));
      case ($urandom_range(3))
         0: tmo = $urandom;
         1: tmo = 32'($urandom_range(0, 1));
         default: tmo = 32'($urandom_range(8));
      endcase
      send_request(func, idx, tmo, $urandom_range(4) == 0, 1'b0, '0);
   endtask

   directed_row_type dir_rows[$];

   initial begin
      sched_result_type none;
      none = '0;
      failures = 0;
      send_idle_pct = 7;
      recv_idle_pct = 62;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FN_TICK;
      req_task_index = '0;
      req_timeout_ticks = '0;
      req_wait_forever = 1'b0;
      csr_valid = 1'b0;
      csr_task_priorities = '0;
      prio_word = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_status[i] = ST_READY;
         slot_count[i] = '0;
      end
      cur_slot = 3'(SLOT_COUNT - 1);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset all priorities are zero: read, tick, then schedule wraps to slot 0
      dir_rows = '{
         '{FN_READ, 8'd7, 32'd0, 1'b0, 1'b1, '{3'd7, 1'b0, 32'd0}},
         '{FN_TICK, 8'd0, 32'd0, 1'b0, 1'b1, '{3'd7, 1'b0, 32'd0}},
         '{FN_SCHEDULE, 8'd0, 32'd0, 1'b0, 1'b1, '{3'd0, 1'b1, 32'd0}},
         '{FN_BLOCK, 8'd0, 32'hFFFFFFFF, 1'b0, 1'b1, '{3'd0, 1'b0, 32'd0}},
         '{FN_READ, 8'd0, 32'd0, 1'b0, 1'b1, '{3'd0, 1'b0, 32'hFFFFFFFF}},
         '{FN_READ, 8'd255, 32'd0, 1'b0, 1'b1, '{3'd0, 1'b0, 32'd0}},
         '{FN_READ, 8'd8, 32'd0, 1'b0, 1'b1, '{3'd0, 1'b0, 32'd0}},
         '{FN_UNBLOCK, 8'd200, 32'd0, 1'b0, 1'b1, '{3'd0, 1'b0, 32'd0}},
         '{3'd5, 8'd0, 32'd0, 1'b0, 1'b1, '{3'd0, 1'b0, 32'd0}},
         '{3'd7, 8'hFF, 32'hFFFFFFFF, 1'b1, 1'b1, '{3'd0, 1'b0, 32'd0}},
         '{FN_TICK, 8'd0, 32'd0, 1'b0, 1'b0, none},
         '{FN_SCHEDULE, 8'd0, 32'd0, 1'b0, 1'b0, none},
         '{FN_BLOCK, 8'd0, 32'd5, 1'b1, 1'b0, none},
         '{FN_READ, 8'd1, 32'd0, 1'b0, 1'b0, none},
         '{FN_UNBLOCK, 8'd1, 32'd0, 1'b0, 1'b0, none},
         '{FN_UNBLOCK, 8'd1, 32'd0, 1'b0, 1'b0, none},
         '{FN_SCHEDULE, 8'd0, 32'd0, 1'b0, 1'b0, none},
         '{FN_BLOCK, 8'd0, 32'd0, 1'b0, 1'b0, none},
         '{FN_SCHEDULE, 8'd0, 32'd0, 1'b0, 1'b0, none},
         '{FN_BLOCK, 8'd0, 32'd1, 1'b0, 1'b0, none},
         '{FN_TICK, 8'd0, 32'd0, 1'b0, 1'b0, none},
         '{FN_SCHEDULE, 8'd0, 32'd0, 1'b0, 1'b0, none}
      };
      foreach (dir_rows[i])
         send_request(dir_rows[i].func, dir_rows[i].task_index, dir_rows[i].timeout_ticks,
                      dir_rows[i].wait_forever, dir_rows[i].check_fixed, dir_rows[i].fixed);
      drain_results();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_priorities(64'hFFFFFFFFFFFFFFFF);
            1: write_priorities(64'h0102030405060708);
            2: write_priorities({$urandom, $urandom});
            3: write_priorities(64'h0000000000000000);
            4: write_priorities(64'h00FF00FF00FF00FF);
            default: write_priorities({4{8'($urandom_range(2)), 8'($urandom_range(2))}});
         endcase
         if (phase == 2) begin
            send_idle_pct = 62;
            recv_idle_pct = 7;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < RANDOM_REQUESTS / 6; n++) begin
            send_random();
            // hold the sender until the scheduler has emptied
            if (n == 40) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_results.size() != 0) @(posedge clock);
            end
         end
         drain_results();
      end

      if (failures == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/prr_pkg.sv
design/prr_ram.sv
design/priority_round_robin_task_scheduler.sv
design/prr_checker.sv
tb/sv/priority_round_robin_task_scheduler_test.sv
